/* design/ptb_pkg.sv */
// ----------------------------------------------------------------------------
// ptb_pkg: shared types and constants of the shielded transaction parser
// Phase codes, error and status codes, configuration and result bundles.
// ----------------------------------------------------------------------------
package ptb_pkg;

   localparam int REM_BITS = 24;

   typedef enum logic [4:0] {
      PH_HEADER        = 5'd0,
      PH_GROUP         = 5'd1,
      PH_IN_COUNT      = 5'd2,
      PH_PREVOUT       = 5'd3,
      PH_IN_SCRIPT_LEN = 5'd4,
      PH_IN_SCRIPT     = 5'd5,
      PH_SEQUENCE      = 5'd6,
      PH_OUT_COUNT     = 5'd7,
      PH_OUT_VALUE     = 5'd8,
      PH_OUT_SCRIPT_LEN= 5'd9,
      PH_OUT_SCRIPT    = 5'd10,
      PH_LOCK_TIME     = 5'd11,
      PH_EXPIRY        = 5'd12,
      PH_VALUE_BAL     = 5'd13,
      PH_SPEND_COUNT   = 5'd14,
      PH_SPEND         = 5'd15,
      PH_SOUT_COUNT    = 5'd16,
      PH_SOUT          = 5'd17,
      PH_JOIN_COUNT    = 5'd18,
      PH_JOIN_BODY     = 5'd19,
      PH_JOIN_PROOF    = 5'd20,
      PH_JOIN_PUBKEY   = 5'd21,
      PH_JOIN_SIG      = 5'd22,
      PH_BINDING_SIG   = 5'd23,
      PH_IDLE          = 5'd24
   } phase_type;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_TRUNCATED  = 3'd1;
   localparam logic [2:0] ERR_VERSION    = 3'd2;
   localparam logic [2:0] ERR_COUNT_MAX  = 3'd3;
   localparam logic [2:0] ERR_COUNT_REM  = 3'd4;
   localparam logic [2:0] ERR_SCRIPT     = 3'd5;

   localparam logic [1:0] ST_BUSY     = 2'd0;
   localparam logic [1:0] ST_COMPLETE = 2'd1;
   localparam logic [1:0] ST_ERROR    = 2'd2;
   localparam logic [1:0] ST_IGNORED  = 2'd3;

   localparam logic [1:0] FMT_LEGACY    = 2'd0;
   localparam logic [1:0] FMT_OVERWINTER= 2'd1;
   localparam logic [1:0] FMT_SAPLING   = 2'd2;

   localparam logic [2:0] REG_OVW_GROUP  = 3'd0;
   localparam logic [2:0] REG_SAP_GROUP  = 3'd1;
   localparam logic [2:0] REG_MAX_IN     = 3'd2;
   localparam logic [2:0] REG_MAX_OUT    = 3'd3;
   localparam logic [2:0] REG_MAX_SCRIPT = 3'd4;
   localparam logic [2:0] REG_MAX_SPEND  = 3'd5;
   localparam logic [2:0] REG_MAX_SOUT   = 3'd6;
   localparam logic [2:0] REG_MAX_JOIN   = 3'd7;

   typedef struct packed {
      logic [31:0] ovw_group;
      logic [31:0] sap_group;
      logic [16:0] max_in;
      logic [16:0] max_out;
      logic [13:0] max_script;
      logic [12:0] max_spend;
      logic [12:0] max_sout;
      logic [12:0] max_join;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  error_code;
      logic [1:0]  status;
      logic [30:0] tx_version;
      logic [1:0]  format_kind;
      logic [13:0] field_offset;
      logic [15:0] element_index;
      logic [4:0]  field_code;
   } result_type;

   function automatic logic [1:0] format_of(input logic [31:0] hdr, input logic [31:0] grp,
                                            input cfg_type cfg);
      logic [1:0] f;
      f = FMT_LEGACY;
      if (hdr[31]) begin
         if (grp == cfg.ovw_group && hdr[30:0] == 31'd3) f = FMT_OVERWINTER;
         else if (grp == cfg.sap_group && hdr[30:0] == 31'd4) f = FMT_SAPLING;
      end
      return f;
   endfunction

endpackage

/* design/ptb_cfg.sv */
// ----------------------------------------------------------------------------
// ptb_cfg: configuration registers
// Group ids, count limits and the script length limit, written through the plain write port.
// ----------------------------------------------------------------------------
module ptb_cfg (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output ptb_pkg::cfg_type  cfg
);
   import ptb_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_OVW_GROUP:  cfg_in.ovw_group  = csr_wdata;
            REG_SAP_GROUP:  cfg_in.sap_group  = csr_wdata;
            REG_MAX_IN:     cfg_in.max_in     = csr_wdata[16:0];
            REG_MAX_OUT:    cfg_in.max_out    = csr_wdata[16:0];
            REG_MAX_SCRIPT: cfg_in.max_script = csr_wdata[13:0];
            REG_MAX_SPEND:  cfg_in.max_spend  = csr_wdata[12:0];
            REG_MAX_SOUT:   cfg_in.max_sout   = csr_wdata[12:0];
            REG_MAX_JOIN:   cfg_in.max_join   = csr_wdata[12:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ovw_group  <= 32'h03C4_8270;
         cfg_ff.sap_group  <= 32'h892F_2085;
         cfg_ff.max_in     <= 17'd65536;
         cfg_ff.max_out    <= 17'd65536;
         cfg_ff.max_script <= 14'd10000;
         cfg_ff.max_spend  <= 13'd4096;
         cfg_ff.max_sout   <= 13'd4096;
         cfg_ff.max_join   <= 13'd4096;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/ptb_core.sv */
// ----------------------------------------------------------------------------
// ptb_core: parser state and per-byte tagging logic
// Holds phase, counters and header words; tags one byte per advance.
// ----------------------------------------------------------------------------
module ptb_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [7:0]                        data_byte,
   input  logic                              first_byte,
   input  logic [ptb_pkg::REM_BITS-1:0]      bytes_after,
   input  ptb_pkg::cfg_type                  cfg,
   output ptb_pkg::result_type               result
);
   import ptb_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [13:0] bc_ff, bc_in;
   logic [16:0] ec_ff, ec_in;
   logic [16:0] et_ff, et_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] hdr_ff, hdr_in;
   logic [31:0] grp_ff, grp_in;
   logic [1:0]  sseen_ff, sseen_in;
   logic [3:0]  need_ff, need_in;

   // effective state after an optional restart
   phase_type   ph;
   logic [13:0] bc;
   logic [16:0] ec, et;
   logic [63:0] acc;
   logic [31:0] hdr, grp;
   logic [1:0]  sseen;
   logic [3:0]  need;

   logic [2:0]  err;
   logic        done;
   logic [1:0]  fmt_cur;

   always_comb begin
      if (first_byte) begin
         ph = PH_HEADER; bc = '0; ec = '0; et = '0; acc = '0;
         hdr = '0; grp = '0; sseen = '0; need = '0;
      end else begin
         ph = phase_ff; bc = bc_ff; ec = ec_ff; et = et_ff; acc = acc_ff;
         hdr = hdr_ff; grp = grp_ff; sseen = sseen_ff; need = need_ff;
      end
   end

   assign fmt_cur = format_of(hdr, grp, cfg);

   // next state
   logic [14:0] bc_inc;
   logic        cs_done;
   logic [63:0] cs_acc;
   logic [13:0] cs_bc;
   logic [3:0]  cs_need;
   logic [2:0]  cs_sh;
   logic [16:0] cnt_max;
   logic [10:0] cnt_unit;
   logic [27:0] cnt_prod;
   logic [2:0]  cnt_err;
   logic        rem_zero;
   logic        ne_req, ne_sap, as_req, fin_req;
   phase_type   ne_again, ne_after;
   logic [16:0] ec_next;
   logic [14:0] proof_len;

   always_comb begin
      bc_inc = {1'b0, bc} + 15'd1;

      // compact size take
      cs_sh   = bc[2:0] - 3'd1;
      cs_done = 1'b0;
      cs_acc  = acc;
      cs_bc   = bc;
      cs_need = need;
      if (bc == 14'd0) begin
         if (data_byte < 8'hFD) begin
            cs_done = 1'b1;
            cs_acc  = {56'd0, data_byte};
         end else begin
            cs_need = (data_byte == 8'hFD) ? 4'd2 : (data_byte == 8'hFE) ? 4'd4 : 4'd8;
            cs_acc  = '0;
            cs_bc   = 14'd1;
         end
      end else begin
         cs_acc = acc | ({56'd0, data_byte} << {cs_sh, 3'b000});
         if (bc >= {10'd0, need}) cs_done = 1'b1;
         else cs_bc = bc_inc[13:0];
      end

      // count guard: limit, then bytes needed against bytes remaining
      case (ph)
         PH_IN_COUNT:    begin cnt_max = cfg.max_in;            cnt_unit = 11'd41;   end
         PH_OUT_COUNT:   begin cnt_max = cfg.max_out;           cnt_unit = 11'd9;    end
         PH_SPEND_COUNT: begin cnt_max = {4'd0, cfg.max_spend}; cnt_unit = 11'd384;  end
         PH_SOUT_COUNT:  begin cnt_max = {4'd0, cfg.max_sout};  cnt_unit = 11'd948;  end
         default:        begin cnt_max = {4'd0, cfg.max_join};  cnt_unit = 11'd1634; end
      endcase
      cnt_prod = 28'(cs_acc[16:0]) * 28'(cnt_unit);
      if ((|cs_acc[63:17]) || cs_acc[16:0] > cnt_max) cnt_err = ERR_COUNT_MAX;
      else if (cnt_prod > 28'(bytes_after)) cnt_err = ERR_COUNT_REM;
      else cnt_err = ERR_NONE;

      rem_zero  = (bytes_after == '0);
      proof_len = (fmt_cur == FMT_SAPLING) ? 15'd192 : 15'd296;

      phase_in = ph; bc_in = bc; ec_in = ec; et_in = et; acc_in = acc;
      hdr_in = hdr; grp_in = grp; sseen_in = sseen; need_in = need;
      err = ERR_NONE; done = 1'b0;
      ne_req = 1'b0; ne_sap = 1'b0; as_req = 1'b0; fin_req = 1'b0;
      ne_again = ph; ne_after = ph;

      case (ph)
         PH_HEADER: begin
            hdr_in = hdr | ({24'd0, data_byte} << {bc[1:0], 3'b000});
            if (bc_inc < 15'd4) bc_in = bc_inc[13:0];
            else begin
               phase_in = hdr_in[31] ? PH_GROUP : PH_IN_COUNT; bc_in = '0;
            end
         end
         PH_GROUP: begin
            grp_in = grp | ({24'd0, data_byte} << {bc[1:0], 3'b000});
            if (bc_inc < 15'd4) bc_in = bc_inc[13:0];
            else if (format_of(hdr, grp_in, cfg) == FMT_LEGACY) err = ERR_VERSION;
            else begin phase_in = PH_IN_COUNT; bc_in = '0; end
         end
         PH_IN_COUNT, PH_OUT_COUNT, PH_SPEND_COUNT, PH_SOUT_COUNT, PH_JOIN_COUNT: begin
            acc_in = cs_acc; bc_in = cs_bc; need_in = cs_need;
            if (cs_done) begin
               err = cnt_err;
               if (cnt_err == ERR_NONE) begin
                  et_in = cs_acc[16:0]; ec_in = '0; bc_in = '0;
                  case (ph)
                     PH_IN_COUNT:
                        phase_in = (cs_acc[16:0] != '0) ? PH_PREVOUT : PH_OUT_COUNT;
                     PH_OUT_COUNT:
                        phase_in = (cs_acc[16:0] != '0) ? PH_OUT_VALUE : PH_LOCK_TIME;
                     PH_SPEND_COUNT: begin
                        if (cs_acc[16:0] != '0) sseen_in[0] = 1'b1;
                        phase_in = (cs_acc[16:0] != '0) ? PH_SPEND : PH_SOUT_COUNT;
                     end
                     PH_SOUT_COUNT: begin
                        if (cs_acc[16:0] != '0) begin
                           sseen_in[1] = 1'b1; phase_in = PH_SOUT;
                        end else as_req = 1'b1;
                     end
                     default: begin
                        if (cs_acc[16:0] != '0) phase_in = PH_JOIN_BODY;
                        else fin_req = 1'b1;
                     end
                  endcase
               end
            end
         end
         PH_PREVOUT: begin
            if (bc_inc < 15'd36) bc_in = bc_inc[13:0];
            else begin phase_in = PH_IN_SCRIPT_LEN; bc_in = '0; end
         end
         PH_IN_SCRIPT_LEN, PH_OUT_SCRIPT_LEN: begin
            acc_in = cs_acc; bc_in = cs_bc; need_in = cs_need;
            if (cs_done) begin
               bc_in = '0;
               if (cs_acc > {50'd0, cfg.max_script}) err = ERR_SCRIPT;
               else if (cs_acc != '0)
                  phase_in = (ph == PH_IN_SCRIPT_LEN) ? PH_IN_SCRIPT : PH_OUT_SCRIPT;
               else if (ph == PH_IN_SCRIPT_LEN) phase_in = PH_SEQUENCE;
               else begin ne_req = 1'b1; ne_again = PH_OUT_VALUE; ne_after = PH_LOCK_TIME; end
            end
         end
         PH_IN_SCRIPT, PH_OUT_SCRIPT: begin
            if (bc_inc < {1'b0, acc[13:0]}) bc_in = bc_inc[13:0];
            else if (ph == PH_IN_SCRIPT) begin phase_in = PH_SEQUENCE; bc_in = '0; end
            else begin ne_req = 1'b1; ne_again = PH_OUT_VALUE; ne_after = PH_LOCK_TIME; end
         end
         PH_SEQUENCE: begin
            if (bc_inc < 15'd4) bc_in = bc_inc[13:0];
            else begin ne_req = 1'b1; ne_again = PH_PREVOUT; ne_after = PH_OUT_COUNT; end
         end
         PH_OUT_VALUE: begin
            if (bc_inc < 15'd8) bc_in = bc_inc[13:0];
            else begin phase_in = PH_OUT_SCRIPT_LEN; bc_in = '0; end
         end
         PH_LOCK_TIME: begin
            if (bc_inc < 15'd4) bc_in = bc_inc[13:0];
            else if (fmt_cur != FMT_LEGACY) begin phase_in = PH_EXPIRY; bc_in = '0; end
            else as_req = 1'b1;
         end
         PH_EXPIRY: begin
            if (bc_inc < 15'd4) bc_in = bc_inc[13:0];
            else if (fmt_cur == FMT_SAPLING) begin phase_in = PH_VALUE_BAL; bc_in = '0; end
            else as_req = 1'b1;
         end
         PH_VALUE_BAL: begin
            if (bc_inc < 15'd8) bc_in = bc_inc[13:0];
            else begin phase_in = PH_SPEND_COUNT; bc_in = '0; end
         end
         PH_SPEND: begin
            if (bc_inc < 15'd384) bc_in = bc_inc[13:0];
            else begin ne_req = 1'b1; ne_again = PH_SPEND; ne_after = PH_SOUT_COUNT; end
         end
         PH_SOUT: begin
            if (bc_inc < 15'd948) bc_in = bc_inc[13:0];
            else begin ne_req = 1'b1; ne_sap = 1'b1; ne_again = PH_SOUT; end
         end
         PH_JOIN_BODY: begin
            if (bc == 14'd303) begin phase_in = PH_JOIN_PROOF; bc_in = '0; end
            else if (bc >= 14'd1441) begin
               ne_req = 1'b1; ne_again = PH_JOIN_BODY; ne_after = PH_JOIN_PUBKEY;
            end else bc_in = bc_inc[13:0];
         end
         PH_JOIN_PROOF: begin
            if (bc_inc < proof_len) bc_in = bc_inc[13:0];
            else begin phase_in = PH_JOIN_BODY; bc_in = 14'd304; end
         end
         PH_JOIN_PUBKEY: begin
            if (bc_inc < 15'd32) bc_in = bc_inc[13:0];
            else begin phase_in = PH_JOIN_SIG; bc_in = '0; end
         end
         PH_JOIN_SIG: begin
            if (bc_inc < 15'd64) bc_in = bc_inc[13:0];
            else fin_req = 1'b1;
         end
         PH_BINDING_SIG: begin
            if (bc_inc < 15'd64) bc_in = bc_inc[13:0];
            else done = 1'b1;
         end
         default: ;
      endcase

      // advance to the next list element, or leave the list
      ec_next = ec + 17'd1;
      if (ne_req) begin
         ec_in = ec_next; bc_in = '0;
         if (ec_next < et) phase_in = ne_again;
         else if (ne_sap) as_req = 1'b1;
         else phase_in = ne_after;
      end
      // after the shielded section, or where a format has none: joinsplits from version 2 on
      if (as_req) begin
         if (hdr[30:0] >= 31'd2) begin phase_in = PH_JOIN_COUNT; bc_in = '0; end
         else fin_req = 1'b1;
      end
      if (fin_req) begin
         if (fmt_cur == FMT_SAPLING && sseen_in != 2'd0) begin
            phase_in = PH_BINDING_SIG; bc_in = '0;
         end else done = 1'b1;
      end

      if (err == ERR_NONE && !done && rem_zero) err = ERR_TRUNCATED;
      if (err != ERR_NONE || done) phase_in = PH_IDLE;
      if (ph == PH_IDLE) begin
         phase_in = ph; bc_in = bc; ec_in = ec; et_in = et; acc_in = acc;
         hdr_in = hdr; grp_in = grp; sseen_in = sseen; need_in = need;
         err = ERR_NONE; done = 1'b0;
      end
   end

   // tag outputs
   logic idx_used;
   always_comb begin
      idx_used = (ph >= PH_PREVOUT && ph <= PH_SEQUENCE) ||
                 (ph >= PH_OUT_VALUE && ph <= PH_OUT_SCRIPT) ||
                 ph == PH_SPEND || ph == PH_SOUT || ph == PH_JOIN_BODY || ph == PH_JOIN_PROOF;
      result = '0;
      if (ph == PH_IDLE) begin
         result.field_code = PH_IDLE;
         result.status     = ST_IGNORED;
      end else begin
         result.field_code    = ph;
         result.element_index = idx_used ? ec[15:0] : 16'd0;
         result.field_offset  = bc;
         if (ph != PH_HEADER || bc >= 14'd3) result.tx_version = hdr_in[30:0];
         if (ph >= PH_IN_COUNT || (ph == PH_GROUP && bc >= 14'd3) ||
             (ph == PH_HEADER && bc >= 14'd3 && !hdr_in[31]))
            result.format_kind = (err == ERR_VERSION) ? FMT_LEGACY
                                                      : format_of(hdr_in, grp_in, cfg);
         result.error_code = err;
         result.status = (err != ERR_NONE) ? ST_ERROR : done ? ST_COMPLETE : ST_BUSY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         bc_ff    <= '0;
         ec_ff    <= '0;
         et_ff    <= '0;
         acc_ff   <= '0;
         hdr_ff   <= '0;
         grp_ff   <= '0;
         sseen_ff <= '0;
         need_ff  <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         bc_ff    <= bc_in;
         ec_ff    <= ec_in;
         et_ff    <= et_in;
         acc_ff   <= acc_in;
         hdr_ff   <= hdr_in;
         grp_ff   <= grp_in;
         sseen_ff <= sseen_in;
         need_ff  <= need_in;
      end
   end

endmodule

/* design/parse_shielded_transaction_bytes.sv */
// ----------------------------------------------------------------------------
// parse_shielded_transaction_bytes: streaming tagger for shielded transactions
// Tags every byte of a serialized transaction with its field and position.
// ----------------------------------------------------------------------------
// One byte per transfer goes in, one tag per transfer comes out, one byte per
// clock sustained while rsp_tready is held high. A byte lands in an input
// register; the parser state is updated as it moves on into the result
// register, which waits while an offered tag is not taken. The rate is set
// by the phase and counter update, which every byte passes exactly once.
// Assert req_tuser on the first byte of each transaction to restart parsing
// at the header; after completion or error, bytes without it are tagged as
// ignored. bytes_after tells the count guards how much stream is left.
module parse_shielded_transaction_bytes (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] data_byte, [31:8] bytes_after
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // req_tuser: [0] first_byte
   input  logic        req_tuser,
   // rsp_tdata: [4:0] field_code, [20:5] element_index, [34:21] field_offset,
   //   [36:35] format_kind, [67:37] tx_version, [69:68] status,
   //   [72:70] error_code, [79:73] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import ptb_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_first_ff;
   logic [REM_BITS-1:0] in_rem_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;
   logic              advance;

   ptb_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // advance the held byte when the result slot is free or being drained
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   ptb_core u_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .data_byte   (in_byte_ff),
      .first_byte  (in_first_ff),
      .bytes_after (in_rem_ff),
      .cfg         (cfg),
      .result      (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (advance) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload holds: capture on transfer only
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata[7:0];
         in_rem_ff   <= req_tdata[8 +: REM_BITS];
         in_first_ff <= req_tuser;
      end
      if (advance) rsp_data_ff <= result;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for parse_shielded_transaction_bytes
// Streams legacy, overwinter and sapling transactions (well formed, truncated,
// corrupted, padded) plus stray bytes through the parser, predicts the tag of
// every byte with a local parser model and compares each returned tag field
// by field, under several register settings and stall patterns.
// ----------------------------------------------------------------------------
module testbench;
   import ptb_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = REG_OVW_GROUP;
   logic [31:0] csr_wdata = '0;

   parse_shielded_transaction_bytes u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] data_byte, [31:8] bytes_after
      .req_tuser  (req_tuser),   // [0] first_byte
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // field_code, element_index, field_offset,
                                 // format_kind, tx_version, status, error_code
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Local copy of the registers and the parser state
   // ------------------------------------------------------------------------
   logic [31:0] cfg_ovw = 32'h03C48270;
   logic [31:0] cfg_sap = 32'h892F2085;
   int unsigned cfg_max_in = 65536, cfg_max_out = 65536, cfg_max_script = 10000;
   int unsigned cfg_max_spend = 4096, cfg_max_sout = 4096, cfg_max_join = 4096;

   int unsigned p_phase, p_elem, p_total, p_bc, p_need, p_shield;
   logic [63:0] p_acc;
   logic [31:0] p_hdr, p_grp;
   bit          p_done;

   result_type  tags_due[$];
   logic [7:0]  tx_q[$];

   int unsigned gap_pct, stall_pct;
   int unsigned items_sent, tags_seen, tx_built, n_complete, n_error, n_ignored;
   int unsigned mismatches, idle_cycles;

   function automatic void restart_parse();
      p_phase = PH_HEADER; p_elem = 0; p_total = 0; p_bc = 0; p_acc = '0;
      p_hdr = '0; p_grp = '0; p_shield = 0; p_need = 0;
   endfunction

   function automatic logic [1:0] kind_now();
      if (!p_hdr[31]) return FMT_LEGACY;
      if (p_grp == cfg_ovw && p_hdr[30:0] == 31'd3) return FMT_OVERWINTER;
      if (p_grp == cfg_sap && p_hdr[30:0] == 31'd4) return FMT_SAPLING;
      return FMT_LEGACY;
   endfunction

   function automatic void goto_phase(int unsigned ph);
      p_phase = ph; p_bc = 0;
   endfunction

   // true on the last byte of a fixed-length field, else advance the offset
   function automatic bit at_field_end(int unsigned len);
      if (p_bc + 1 < len) begin
         p_bc++;
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // accumulate a compact size; true once its last byte is in
   function automatic bit size_done(logic [7:0] b);
      if (p_bc == 0) begin
         if (b < 8'hFD) begin
            p_acc = 64'(b);
            return 1'b1;
         end
         p_need = (b == 8'hFD) ? 2 : (b == 8'hFE) ? 4 : 8;
         p_acc = '0; p_bc = 1;
         return 1'b0;
      end
      p_acc |= 64'(b) << ((8 * (p_bc - 1)) & 63);
      if (p_bc >= p_need) return 1'b1;
      p_bc++;
      return 1'b0;
   endfunction

   function automatic logic [2:0] count_guard(int unsigned lim, longint unsigned unit,
                                              logic [23:0] rem);
      if (p_acc > 64'(lim)) return ERR_COUNT_MAX;
      if (p_acc * unit > 64'(rem)) return ERR_COUNT_REM;
      p_total = p_acc; p_elem = 0;
      return ERR_NONE;
   endfunction

   function automatic void wrap_up();
      if (kind_now() == FMT_SAPLING && p_shield != 0) goto_phase(PH_BINDING_SIG);
      else p_done = 1'b1;
   endfunction

   function automatic void after_shielded();
      if (p_hdr[30:0] >= 31'd2) goto_phase(PH_JOIN_COUNT);
      else wrap_up();
   endfunction

   function automatic void next_element(int unsigned again, int unsigned after);
      p_elem++;
      goto_phase(p_elem < p_total ? again : after);
   endfunction

   // expected tag for one byte; advances the local parser state
   function automatic result_type tag_byte(logic [7:0] b, logic first, logic [23:0] rem);
      result_type  r;
      int unsigned fld, off, idx;
      logic [2:0]  err;
      logic [1:0]  st, fmt;
      logic [30:0] ver;
      r = '0;
      if (first) restart_parse();
      if (p_phase >= PH_IDLE) begin
         r.field_code = PH_IDLE;
         r.status = ST_IGNORED;
         return r;
      end
      fld = p_phase; off = p_bc; idx = p_elem & 16'hFFFF;
      p_done = 1'b0; err = ERR_NONE; fmt = FMT_LEGACY; ver = '0;
      case (fld)
         PH_HEADER: begin
            p_hdr |= 32'(b) << ((8 * off) & 31);
            if (at_field_end(4)) goto_phase(p_hdr[31] ? PH_GROUP : PH_IN_COUNT);
         end
         PH_GROUP: begin
            p_grp |= 32'(b) << ((8 * off) & 31);
            if (at_field_end(4)) begin
               if (kind_now() == FMT_LEGACY) err = ERR_VERSION;
               else goto_phase(PH_IN_COUNT);
            end
         end
         PH_IN_COUNT: if (size_done(b)) begin
            err = count_guard(cfg_max_in, 41, rem);
            if (err == ERR_NONE) goto_phase(p_total != 0 ? PH_PREVOUT : PH_OUT_COUNT);
         end
         PH_PREVOUT: if (at_field_end(36)) goto_phase(PH_IN_SCRIPT_LEN);
         PH_IN_SCRIPT_LEN, PH_OUT_SCRIPT_LEN: if (size_done(b)) begin
            if (p_acc > 64'(cfg_max_script)) err = ERR_SCRIPT;
            else if (p_acc != 0) goto_phase(fld + 1);
            else if (fld == PH_IN_SCRIPT_LEN) goto_phase(PH_SEQUENCE);
            else next_element(PH_OUT_VALUE, PH_LOCK_TIME);
         end
         PH_IN_SCRIPT, PH_OUT_SCRIPT: begin
            if (64'(p_bc) + 1 < p_acc) p_bc++;
            else if (fld == PH_IN_SCRIPT) goto_phase(PH_SEQUENCE);
            else next_element(PH_OUT_VALUE, PH_LOCK_TIME);
         end
         PH_SEQUENCE: if (at_field_end(4)) next_element(PH_PREVOUT, PH_OUT_COUNT);
         PH_OUT_COUNT: if (size_done(b)) begin
            err = count_guard(cfg_max_out, 9, rem);
            if (err == ERR_NONE) goto_phase(p_total != 0 ? PH_OUT_VALUE : PH_LOCK_TIME);
         end
         PH_OUT_VALUE: if (at_field_end(8)) goto_phase(PH_OUT_SCRIPT_LEN);
         PH_LOCK_TIME: if (at_field_end(4)) begin
            if (kind_now() != FMT_LEGACY) goto_phase(PH_EXPIRY);
            else after_shielded();
         end
         PH_EXPIRY: if (at_field_end(4)) begin
            if (kind_now() == FMT_SAPLING) goto_phase(PH_VALUE_BAL);
            else after_shielded();
         end
         PH_VALUE_BAL: if (at_field_end(8)) goto_phase(PH_SPEND_COUNT);
         PH_SPEND_COUNT: if (size_done(b)) begin
            err = count_guard(cfg_max_spend, 384, rem);
            if (err == ERR_NONE) begin
               if (p_total != 0) p_shield |= 1;
               goto_phase(p_total != 0 ? PH_SPEND : PH_SOUT_COUNT);
            end
         end
         PH_SPEND: if (at_field_end(384)) next_element(PH_SPEND, PH_SOUT_COUNT);
         PH_SOUT_COUNT: if (size_done(b)) begin
            err = count_guard(cfg_max_sout, 948, rem);
            if (err == ERR_NONE) begin
               if (p_total != 0) begin
                  p_shield |= 2;
                  goto_phase(PH_SOUT);
               end else after_shielded();
            end
         end
         PH_SOUT: if (at_field_end(948)) begin
            p_elem++;
            if (p_elem < p_total) goto_phase(PH_SOUT);
            else after_shielded();
         end
         PH_JOIN_COUNT: if (size_done(b)) begin
            err = count_guard(cfg_max_join, 1634, rem);
            if (err == ERR_NONE) begin
               if (p_total != 0) goto_phase(PH_JOIN_BODY);
               else wrap_up();
            end
         end
         PH_JOIN_BODY: begin
            // body is split around the proof at offset 304
            if (p_bc == 303) goto_phase(PH_JOIN_PROOF);
            else if (p_bc >= 1441) next_element(PH_JOIN_BODY, PH_JOIN_PUBKEY);
            else p_bc++;
         end
         PH_JOIN_PROOF: if (at_field_end(kind_now() == FMT_SAPLING ? 192 : 296)) begin
            p_phase = PH_JOIN_BODY; p_bc = 304;
         end
         PH_JOIN_PUBKEY: if (at_field_end(32)) goto_phase(PH_JOIN_SIG);
         PH_JOIN_SIG: if (at_field_end(64)) wrap_up();
         default: if (at_field_end(64)) p_done = 1'b1;
      endcase

      // running out of stream counts only when nothing else failed
      if (err == ERR_NONE && !p_done && rem == 0) err = ERR_TRUNCATED;
      if (err != ERR_NONE) begin
         p_phase = PH_IDLE; st = ST_ERROR;
      end else if (p_done) begin
         p_phase = PH_IDLE; st = ST_COMPLETE;
      end else st = ST_BUSY;

      if (fld > 0 || off >= 3) ver = p_hdr[30:0];
      if (fld >= 2 || (fld == PH_GROUP && off >= 3) ||
          (fld == PH_HEADER && off >= 3 && !p_hdr[31]))
         fmt = (err == ERR_VERSION) ? FMT_LEGACY : kind_now();
      if (!((fld >= PH_PREVOUT && fld <= PH_SEQUENCE) ||
            (fld >= PH_OUT_VALUE && fld <= PH_OUT_SCRIPT) || fld == PH_SPEND ||
            fld == PH_SOUT || fld == PH_JOIN_BODY || fld == PH_JOIN_PROOF))
         idx = 0;

      r.field_code = 5'(fld);
      r.element_index = 16'(idx);
      r.field_offset = 14'(off);
      r.format_kind = fmt;
      r.tx_version = ver;
      r.status = st;
      r.error_code = err;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Receiver stalls, tag checking and watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      result_type want, got;
      got = rsp_tdata[72:0];
      if (!reset && rsp_tvalid && rsp_tready) begin
         tags_seen++;
         case (got.status)
            ST_COMPLETE: n_complete++;
            ST_ERROR:    n_error++;
            ST_IGNORED:  n_ignored++;
            default: ;
         endcase
         if (tags_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected tag %h with nothing outstanding", rsp_tdata);
         end else begin
            want = tags_due.pop_front();
            if (got.field_code != want.field_code || got.element_index != want.element_index ||
                got.field_offset != want.field_offset || got.format_kind != want.format_kind ||
                got.tx_version != want.tx_version || got.status != want.status ||
                got.error_code != want.error_code || rsp_tdata[79:73] != '0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"ERROR: tag %0d field/idx/off/fmt/ver/st/err ",
                            "exp %0d/%0d/%0d/%0d/%h/%0d/%0d act %0d/%0d/%0d/%0d/%h/%0d/%0d pad %h"},
                           tags_seen, want.field_code, want.element_index, want.field_offset,
                           want.format_kind, want.tx_version, want.status, want.error_code,
                           got.field_code, got.element_index, got.field_offset,
                           got.format_kind, got.tx_version, got.status, got.error_code,
                           rsp_tdata[79:73]);
            end
         end
      end
      // any transfer on either side resets the watchdog
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d tags outstanding", tags_due.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // send one byte; valid stays high afterwards, callers that pause drop it
   task automatic send_byte(logic [7:0] b, logic first, logic [23:0] rem);
      if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {rem, b};
      req_tuser <= first;
      do @(posedge clock); while (!req_tready);
      tags_due.push_back(tag_byte(b, first, rem));
      items_sent++;
   endtask

   // hold the input side until every outstanding tag is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tags_due.size() != 0) @(posedge clock);
   endtask

   task automatic load_regs(logic [31:0] ovw, logic [31:0] sap, logic [31:0] mi,
                            logic [31:0] mo, logic [31:0] ms, logic [31:0] msp,
                            logic [31:0] mso, logic [31:0] mj);
      logic [31:0] vals[8];
      vals = '{ovw, sap, mi, mo, ms, msp, mso, mj};
      drain();
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg_ovw = ovw; cfg_sap = sap;
      cfg_max_in = mi & 32'h1FFFF; cfg_max_out = mo & 32'h1FFFF;
      cfg_max_script = ms & 32'h3FFF;
      cfg_max_spend = msp & 32'h1FFF; cfg_max_sout = mso & 32'h1FFF;
      cfg_max_join = mj & 32'h1FFF;
   endtask

   function automatic void push_le(logic [63:0] v, int n);
      for (int i = 0; i < n; i++) tx_q.push_back(v[8 * i +: 8]);
   endfunction

   function automatic void push_size(longint unsigned n);
      if (n < 253) push_le(n, 1);
      else if (n <= 64'hFFFF) begin
         push_le(8'hFD, 1); push_le(n, 2);
      end else if (n <= 64'hFFFF_FFFF) begin
         push_le(8'hFE, 1); push_le(n, 4);
      end else begin
         push_le(8'hFF, 1); push_le(n, 8);
      end
   endfunction

   function automatic void push_noise(int n);
      for (int i = 0; i < n; i++) tx_q.push_back(8'($urandom));
   endfunction

   function automatic void push_script();
      int unsigned len;
      len = ($urandom_range(9) == 0) ? $urandom_range(253, 300) : $urandom_range(0, 12);
      push_size(len);
      push_noise(len);
   endfunction

   // stream the queued bytes; bytes_after counts down to slack
   task automatic send_queue(logic first, logic [23:0] slack);
      int total;
      total = tx_q.size();
      for (int i = 0; i < total; i++)
         send_byte(tx_q[i], first && i == 0, 24'(total - 1 - i) + slack);
   endtask

   // assemble one transaction; most are well formed with random content
   function automatic void build_tx();
      int          kind, n_in, n_out;
      bit          sp, so, jn;
      logic [31:0] hdr;
      tx_q.delete();
      tx_built++;
      kind = $urandom_range(9);
      if (kind <= 2) begin
         hdr = {1'b0, ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(1, 2))};
         push_le(hdr, 4);
      end else if (kind <= 4) begin
         hdr = 32'h8000_0003;
         push_le(hdr, 4); push_le(cfg_ovw, 4);
      end else if (kind <= 8) begin
         hdr = 32'h8000_0004;
         push_le(hdr, 4); push_le(cfg_sap, 4);
      end else begin
         hdr = {1'b1, 31'($urandom)};
         push_le(hdr, 4); push_le($urandom, 4);
      end
      n_in = $urandom_range(0, 2);
      push_size(n_in);
      repeat (n_in) begin
         push_noise(36); push_script(); push_noise(4);
      end
      n_out = $urandom_range(0, 2);
      push_size(n_out);
      repeat (n_out) begin
         push_noise(8); push_script();
      end
      push_noise(4);
      if (kind >= 3 && kind <= 8) push_noise(4);
      sp = 0; so = 0;
      if (kind >= 5 && kind <= 8) begin
         push_noise(8);
         sp = ($urandom_range(6) == 0);
         push_size(sp);
         if (sp) push_noise(384);
         so = ($urandom_range(9) == 0);
         push_size(so);
         if (so) push_noise(948);
      end
      if (hdr[30:0] >= 31'd2) begin
         jn = ($urandom_range(11) == 0);
         push_size(jn);
         if (jn) begin
            push_noise(304);
            push_noise(kind >= 5 && kind <= 8 ? 192 : 296);
            push_noise(1138 + 32 + 64);
         end
      end
      if (sp || so) push_noise(64);
   endfunction

   // one transaction, possibly cut short, corrupted or padded
   task automatic run_tx(int unsigned budget);
      int          r, len;
      logic [23:0] slack;
      build_tx();
      r = $urandom_range(99);
      len = tx_q.size();
      if (r < 10) tx_q = tx_q[0:$urandom_range(0, len - 2)];
      else if (r < 20) tx_q[$urandom_range(0, len - 1)] = 8'($urandom);
      else if (r < 28) push_noise($urandom_range(1, 3));
      // keep long transactions inside what is left of the batch
      if (tx_q.size() > budget) tx_q = tx_q[0:budget - 1];
      slack = ($urandom_range(9) == 0) ? 24'($urandom) : 24'd0;
      send_queue($urandom_range(19) != 0, slack);
      // stray bytes between transactions
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 3))
            send_byte(8'($urandom), $urandom_range(3) == 0, 24'($urandom));
   endtask

   task automatic random_batch(int unsigned target);
      int unsigned start;
      start = items_sent;
      while (items_sent - start < target) run_tx(target - (items_sent - start));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      gap_pct = 7; stall_pct = 67;
      // bare legacy transaction right after reset, no restart flag
      tx_q.delete();
      push_le(1, 4); push_size(0); push_size(0); push_le(32'hFFFF_FFFF, 4);
      send_queue(1'b0, 24'd0);
      // stray byte after completion is ignored
      send_byte(8'hA5, 1'b0, 24'hFF_FFFF);
      drain();
      // restart in the middle of a header
      tx_q.delete(); push_le(0, 2);
      send_queue(1'b1, 24'd5);
      // overwinter bit with an unknown version
      tx_q.delete(); push_le(32'h8000_0005, 4); push_le(cfg_sap, 4);
      send_queue(1'b1, 24'd3);
      // input count above its limit, 4-byte compact size
      tx_q.delete(); push_le(1, 4); push_size(64'hFFFF_FFFF);
      send_queue(1'b1, 24'd0);
      // input count larger than the rest of the stream, 8-byte compact size
      tx_q.delete(); push_le(2, 4); push_le(8'hFF, 1); push_le(5, 8);
      send_queue(1'b1, 24'd0);
      // script length above the script limit
      tx_q.delete(); push_le(1, 4); push_size(1); push_noise(36); push_size(10001);
      send_queue(1'b1, 24'd100);
   endtask

   task automatic test_limits_low();
      load_regs('0, '0, '0, '0, '0, '0, '0, '0);
      random_batch(40);
   endtask

   task automatic test_limits_high();
      load_regs('1, '1, 32'h1FFFF, 32'h1FFFF, 32'h3FFF, 32'h1FFF, 32'h1FFF, 32'h1FFF);
      random_batch(120);
   endtask

   task automatic test_random_mix();
      for (int m = 0; m < 3; m++) begin
         case (m)
            0: begin gap_pct = 7;  stall_pct = 67; end
            1: begin gap_pct = 67; stall_pct = 7;  end
            default: begin gap_pct = 0; stall_pct = 0; end
         endcase
         load_regs($urandom, $urandom,
                   $urandom_range(3) == 0 ? $urandom_range(0, 2) : 65536,
                   $urandom_range(3) == 0 ? $urandom_range(0, 2) : 65536,
                   $urandom_range(3) == 0 ? $urandom_range(0, 300) : 10000,
                   $urandom_range(3) == 0 ? 0 : 4096,
                   $urandom_range(3) == 0 ? 0 : 4096,
                   $urandom_range(3) == 0 ? 0 : 4096);
         random_batch(60);
      end
   endtask

   initial begin
      restart_parse();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_limits_low();
      test_limits_high();
      test_random_mix();
      drain();
      repeat (8) @(posedge clock);
      $display("Tagged %0d bytes from %0d generated transactions under 6 register settings",
               items_sent, tx_built);
      $display("Tags seen: %0d complete, %0d error, %0d ignored; %0d mismatches",
               n_complete, n_error, n_ignored, mismatches);
      if (mismatches == 0 && tags_due.size() == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule

/* sim.f */
design/ptb_pkg.sv
design/ptb_cfg.sv
design/ptb_core.sv
design/parse_shielded_transaction_bytes.sv
tb/sv/testbench.sv
